// File: sv/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types, constants and helpers for the linked key-value table.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LINK_W   = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;

    typedef logic [LINK_W-1:0] t_link;
    typedef logic [IDX_W-1:0]  t_idx;

    localparam t_link NIL_LINK = t_link'(CAPACITY);

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_SEARCH = 2'd1,
        REQ_REMOVE = 2'd2
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_FOUND  = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] result_value;
        logic [COUNT_W-1:0]       entry_count;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HIT,
        S_FREE,
        S_ALLOC,
        S_APPEND
    } t_state;

    typedef struct packed {
        logic    load;
        logic    scan_step;
        logic    capture_hit;
        logic    upd_value;
        logic    unlink;
        logic    free_slot;
        logic    rd_free;
        logic    alloc;
        logic    append;
        logic    fin;
        t_status fin_status;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic       cur_ok;
        logic       key_match;
        logic       free_ok;
    } t_dp_sts;

    function automatic logic link_ok(input t_link p);
        return p < NIL_LINK;
    endfunction

endpackage

// File: sv/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl
// Request sequencer: scan, hit handling, unlink and append steps.
// ----------------------------------------------------------------------------
module lkv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_req_type,
    input  lkv_pkg::t_dp_sts  i_sts,
    output lkv_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);

    lkv_pkg::t_state r_state;
    lkv_pkg::t_state n_state;
    logic            req_known;

    assign req_known = (i_req_type == lkv_pkg::REQ_ADD)
                    || (i_req_type == lkv_pkg::REQ_SEARCH)
                    || (i_req_type == lkv_pkg::REQ_REMOVE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkv_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lkv_pkg::S_IDLE: begin
                if (i_start && req_known) begin
                    n_state = lkv_pkg::S_SCAN;
                end
            end
            lkv_pkg::S_SCAN: begin
                if (!i_sts.cur_ok) begin
                    if (i_sts.req_type == lkv_pkg::REQ_ADD && i_sts.free_ok) begin
                        n_state = lkv_pkg::S_ALLOC;
                    end else begin
                        n_state = lkv_pkg::S_IDLE;
                    end
                end else if (i_sts.key_match) begin
                    n_state = lkv_pkg::S_HIT;
                end
            end
            lkv_pkg::S_HIT: begin
                if (i_sts.req_type == lkv_pkg::REQ_REMOVE) begin
                    n_state = lkv_pkg::S_FREE;
                end else begin
                    n_state = lkv_pkg::S_IDLE;
                end
            end
            lkv_pkg::S_FREE:   n_state = lkv_pkg::S_IDLE;
            lkv_pkg::S_ALLOC:  n_state = lkv_pkg::S_APPEND;
            lkv_pkg::S_APPEND: n_state = lkv_pkg::S_IDLE;
            default:           n_state = lkv_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.fin_status = lkv_pkg::ST_ABSENT;
        unique case (r_state)
            lkv_pkg::S_IDLE: begin
                if (i_start) begin
                    // An unknown request type is answered at once and changes nothing.
                    o_cmd.load = req_known;
                    o_cmd.fin  = !req_known;
                end
            end
            lkv_pkg::S_SCAN: begin
                if (!i_sts.cur_ok) begin
                    if (i_sts.req_type == lkv_pkg::REQ_ADD) begin
                        if (i_sts.free_ok) begin
                            o_cmd.rd_free = 1'b1;
                        end else begin
                            o_cmd.fin        = 1'b1;
                            o_cmd.fin_status = lkv_pkg::ST_FULL;
                        end
                    end else begin
                        o_cmd.fin = 1'b1;
                    end
                end else if (i_sts.key_match) begin
                    o_cmd.capture_hit = 1'b1;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            lkv_pkg::S_HIT: begin
                if (i_sts.req_type == lkv_pkg::REQ_REMOVE) begin
                    o_cmd.unlink = 1'b1;
                end else begin
                    o_cmd.upd_value  = (i_sts.req_type == lkv_pkg::REQ_ADD);
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = lkv_pkg::ST_FOUND;
                end
            end
            lkv_pkg::S_FREE: begin
                o_cmd.free_slot  = 1'b1;
                o_cmd.fin        = 1'b1;
                o_cmd.fin_status = lkv_pkg::ST_FOUND;
            end
            lkv_pkg::S_ALLOC: begin
                o_cmd.alloc = 1'b1;
            end
            lkv_pkg::S_APPEND: begin
                o_cmd.append = 1'b1;
                o_cmd.fin    = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_busy = (r_state != lkv_pkg::S_IDLE);

endmodule

// File: sv/lkv_dp.sv
// ----------------------------------------------------------------------------
// lkv_dp
// Slot memories, list pointers, entry count and the result register.
// ----------------------------------------------------------------------------
module lkv_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lkv_pkg::t_req              i_req,
    input  logic                       i_cfg_we,
    input  logic [lkv_pkg::DATA_W-1:0] i_cfg_data,
    input  lkv_pkg::t_dp_cmd           i_cmd,
    output lkv_pkg::t_dp_sts           o_sts,
    output lkv_pkg::t_rsp              o_rsp,
    output logic                       o_strobe
);

    // Slot memories. The link memories carry valid bits so that an entry
    // never written reads as its reset link.
    logic [lkv_pkg::DATA_W-1:0] key_mem  [lkv_pkg::CAPACITY];
    logic [lkv_pkg::DATA_W-1:0] val_mem  [lkv_pkg::CAPACITY];
    lkv_pkg::t_link             next_mem [lkv_pkg::CAPACITY];
    lkv_pkg::t_link             prev_mem [lkv_pkg::CAPACITY];
    logic [lkv_pkg::CAPACITY-1:0] r_next_vld;
    logic [lkv_pkg::CAPACITY-1:0] r_prev_vld;

    lkv_pkg::t_req              r_req;
    logic [lkv_pkg::DATA_W-1:0] r_null;
    lkv_pkg::t_link             r_head;
    lkv_pkg::t_link             r_tail;
    lkv_pkg::t_link             r_free;
    lkv_pkg::t_link             r_count;
    lkv_pkg::t_link             n_count;
    lkv_pkg::t_link             r_cur;
    lkv_pkg::t_link             r_steps;
    lkv_pkg::t_link             r_hit;
    lkv_pkg::t_link             r_prev;
    lkv_pkg::t_link             r_next;
    logic [lkv_pkg::DATA_W-1:0] r_old;
    lkv_pkg::t_rsp              r_rsp;
    logic                       r_strobe;

    // Registered read port.
    logic [lkv_pkg::DATA_W-1:0] r_key_q;
    logic [lkv_pkg::DATA_W-1:0] r_val_q;
    lkv_pkg::t_link             r_next_raw;
    lkv_pkg::t_link             r_prev_raw;
    logic                       r_next_v;
    logic                       r_prev_v;
    lkv_pkg::t_idx              r_rd_idx;
    lkv_pkg::t_link             next_q;
    lkv_pkg::t_link             prev_q;
    lkv_pkg::t_idx              rd_addr;

    // Write ports.
    logic                       key_we;
    logic                       val_we;
    lkv_pkg::t_idx              kv_addr;
    lkv_pkg::t_idx              val_addr;
    logic                       next_we;
    lkv_pkg::t_idx              next_addr;
    lkv_pkg::t_link             next_wdata;
    logic                       prev_we;
    lkv_pkg::t_idx              prev_addr;
    lkv_pkg::t_link             prev_wdata;

    assign next_q = r_next_v ? r_next_raw : (lkv_pkg::t_link'(r_rd_idx) + lkv_pkg::t_link'(1));
    assign prev_q = r_prev_v ? r_prev_raw : lkv_pkg::NIL_LINK;

    always_comb begin
        if (i_cmd.load) begin
            rd_addr = r_head[lkv_pkg::IDX_W-1:0];
        end else if (i_cmd.scan_step) begin
            rd_addr = next_q[lkv_pkg::IDX_W-1:0];
        end else if (i_cmd.rd_free) begin
            rd_addr = r_free[lkv_pkg::IDX_W-1:0];
        end else begin
            rd_addr = r_cur[lkv_pkg::IDX_W-1:0];
        end
    end

    always_comb begin
        key_we     = i_cmd.alloc;
        kv_addr    = r_free[lkv_pkg::IDX_W-1:0];
        val_we     = i_cmd.alloc || i_cmd.upd_value;
        val_addr   = i_cmd.alloc ? r_free[lkv_pkg::IDX_W-1:0] : r_hit[lkv_pkg::IDX_W-1:0];

        next_we    = 1'b0;
        next_addr  = r_prev[lkv_pkg::IDX_W-1:0];
        next_wdata = r_next;
        if (i_cmd.unlink) begin
            next_we    = lkv_pkg::link_ok(r_prev);
        end else if (i_cmd.free_slot) begin
            next_we    = 1'b1;
            next_addr  = r_hit[lkv_pkg::IDX_W-1:0];
            next_wdata = r_free;
        end else if (i_cmd.alloc) begin
            next_we    = 1'b1;
            next_addr  = r_free[lkv_pkg::IDX_W-1:0];
            next_wdata = lkv_pkg::NIL_LINK;
        end else if (i_cmd.append) begin
            next_we    = lkv_pkg::link_ok(r_tail);
            next_addr  = r_tail[lkv_pkg::IDX_W-1:0];
            next_wdata = r_hit;
        end

        prev_we    = 1'b0;
        prev_addr  = r_next[lkv_pkg::IDX_W-1:0];
        prev_wdata = r_prev;
        if (i_cmd.unlink) begin
            prev_we    = lkv_pkg::link_ok(r_next);
        end else if (i_cmd.free_slot) begin
            prev_we    = 1'b1;
            prev_addr  = r_hit[lkv_pkg::IDX_W-1:0];
            prev_wdata = lkv_pkg::NIL_LINK;
        end else if (i_cmd.alloc) begin
            prev_we    = 1'b1;
            prev_addr  = r_free[lkv_pkg::IDX_W-1:0];
            prev_wdata = r_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[kv_addr] <= r_req.key;
        end
        if (val_we) begin
            val_mem[val_addr] <= r_req.value;
        end
        if (next_we) begin
            next_mem[next_addr] <= next_wdata;
        end
        if (prev_we) begin
            prev_mem[prev_addr] <= prev_wdata;
        end
        r_key_q    <= key_mem[rd_addr];
        r_val_q    <= val_mem[rd_addr];
        r_next_raw <= next_mem[rd_addr];
        r_prev_raw <= prev_mem[rd_addr];
        r_next_v   <= r_next_vld[rd_addr];
        r_prev_v   <= r_prev_vld[rd_addr];
        r_rd_idx   <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_vld <= '0;
            r_prev_vld <= '0;
        end else begin
            if (next_we) begin
                r_next_vld[next_addr] <= 1'b1;
            end
            if (prev_we) begin
                r_prev_vld[prev_addr] <= 1'b1;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.free_slot && r_count != '0) begin
            n_count = r_count - lkv_pkg::t_link'(1);
        end else if (i_cmd.append && r_count < lkv_pkg::NIL_LINK) begin
            n_count = r_count + lkv_pkg::t_link'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_null   <= '0;
            r_head   <= lkv_pkg::NIL_LINK;
            r_tail   <= lkv_pkg::NIL_LINK;
            r_free   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_null <= i_cfg_data;
            end
            r_count  <= n_count;
            r_strobe <= i_cmd.fin;
            if (i_cmd.unlink) begin
                if (!lkv_pkg::link_ok(r_prev)) begin
                    r_head <= r_next;
                end
                if (!lkv_pkg::link_ok(r_next)) begin
                    r_tail <= r_prev;
                end
            end
            if (i_cmd.free_slot) begin
                r_free <= r_hit;
            end
            if (i_cmd.alloc) begin
                r_free <= next_q;
            end
            if (i_cmd.append) begin
                if (!lkv_pkg::link_ok(r_tail)) begin
                    r_head <= r_hit;
                end
                r_tail <= r_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req;
            r_cur   <= r_head;
            r_steps <= '0;
        end
        if (i_cmd.scan_step) begin
            r_cur   <= next_q;
            r_steps <= r_steps + lkv_pkg::t_link'(1);
        end
        if (i_cmd.capture_hit) begin
            r_hit  <= r_cur;
            r_prev <= prev_q;
            r_next <= next_q;
            r_old  <= r_val_q;
        end
        if (i_cmd.alloc) begin
            // The slot taken from the free list is kept for the append step.
            r_hit <= r_free;
        end
        if (i_cmd.fin) begin
            r_rsp.status       <= i_cmd.fin_status;
            r_rsp.result_value <= (i_cmd.fin_status == lkv_pkg::ST_FOUND) ? r_old : r_null;
            r_rsp.entry_count  <= lkv_pkg::COUNT_W'(n_count);
        end
    end

    assign o_sts.req_type  = r_req.req_type;
    assign o_sts.cur_ok    = lkv_pkg::link_ok(r_cur) && (r_steps < lkv_pkg::NIL_LINK);
    assign o_sts.key_match = (r_key_q == r_req.key);
    assign o_sts.free_ok   = lkv_pkg::link_ok(r_free);

    assign o_rsp    = r_rsp;
    assign o_strobe = r_strobe;

    // Once a request has finished, the list ends and the free list agree with the count.
    a_head_vs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> (lkv_pkg::link_ok(r_head) == (r_count != '0)))
        else $error("list head and entry count disagree");

    a_tail_vs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> (lkv_pkg::link_ok(r_tail) == (r_count != '0)))
        else $error("list tail and entry count disagree");

    a_free_vs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> (lkv_pkg::link_ok(r_free) == (r_count < lkv_pkg::NIL_LINK)))
        else $error("free list head and entry count disagree");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_count <= lkv_pkg::NIL_LINK))
        else $error("entry count beyond capacity");

endmodule

// File: sv/linked_key_value_table.sv
// ----------------------------------------------------------------------------
// linked_key_value_table
// Fixed-capacity key-value table with unique keys, kept in insertion order.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on o_rsp for one cycle with o_strobe high and cannot be held off, so
// the receiver must take it in that cycle. After acceptance the scan walks
// the list through the registered read port of the slot memories, one linked
// slot per cycle, with a final check when the key is not in the list. A
// search or an update that hits then finishes; a remove that hits unlinks the
// entry and then frees its slot; an insert that misses takes a slot from the
// free list and appends it at the tail, or reports full when none is free; an
// unknown request type finishes in the acceptance cycle. The result is
// registered and appears in the cycle after the step that finishes the
// request. Busy is low again in the cycle that carries the result, so the
// next request can be taken while the result is on the outputs. The null value
// register is written over its own channel, which is always ready; write it
// only while the block is idle.
module linked_key_value_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  lkv_pkg::t_req              i_req,
    output logic                       o_strobe,
    output lkv_pkg::t_rsp              o_rsp,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [lkv_pkg::DATA_W-1:0] i_cfg_data
);

    lkv_pkg::t_dp_cmd cmd;
    lkv_pkg::t_dp_sts sts;
    logic             ctrl_busy;

    assign o_cfg_ready = 1'b1;
    assign busy        = ctrl_busy;

    lkv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req.req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (ctrl_busy)
    );

    lkv_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_rsp      (o_rsp),
        .o_strobe   (o_strobe)
    );

endmodule
